### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property checked at every rising edge of clk.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen at a rising edge of clk.
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

### rtl/tfu_pkg.sv
// ---------------------------------------------------------------------------
// tfu_pkg
// Widths, pipeline latencies and series coefficients of the trigamma unit.
// ---------------------------------------------------------------------------
package tfu_pkg;

    localparam int FRAC_BITS = 30;
    localparam int X_W       = 32;
    localparam int D_W       = 33;   // x + k*2^16 for k up to six
    localparam int Q_W       = 63;   // quotient of 2^62 by a nonzero divisor
    localparam int P_W       = 25;   // 1/y^2 in Q.30, y >= 6
    localparam int R_W       = 28;   // 1/y in Q.30, y >= 6
    localparam int T_W       = 32;   // Horner accumulator, two's complement
    localparam int SER_W     = 30;
    localparam int SUM_W     = 64;
    localparam int RES_W     = 48;
    localparam int NUM_DIV   = 7;    // six recurrence terms plus y itself
    localparam int NUM_TERMS = 6;
    localparam int NUM_STEPS = 5;

    localparam int DIV_LAT   = 2 * Q_W;
    localparam int POLY_LAT  = 2 * NUM_STEPS + 2;
    localparam int SUM_LAT   = 3;
    localparam int TOTAL_LAT = DIV_LAT + POLY_LAT + SUM_LAT + 1;

    localparam logic [T_W-1:0] COEF_C5  = 32'd81344078;
    localparam logic [T_W-1:0] COEF_C4  = 32'd35791394;
    localparam logic [T_W-1:0] COEF_C3  = 32'd25565282;
    localparam logic [T_W-1:0] COEF_C1  = 32'd178956971;
    localparam logic [T_W-1:0] COEF_ONE = 32'd1073741824;

    // Constant added after each Horner multiply, in order of evaluation.
    function automatic logic [T_W-1:0] horner_coef(input logic [2:0] step);
        logic [T_W-1:0] c;
        case (step)
            3'd0:    c = ~COEF_C4 + 32'd1;
            3'd1:    c = COEF_C3;
            3'd2:    c = ~COEF_C4 + 32'd1;
            3'd3:    c = COEF_C1;
            3'd4:    c = COEF_ONE;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

### rtl/trigamma_function_unit_core.sv
// ---------------------------------------------------------------------------
// trigamma_function_unit_core
// Fully pipelined trigamma of an unsigned Q16.16 argument, Q24.24 result.
// ---------------------------------------------------------------------------
// The unit accepts one argument per clock while the output is not stalled;
// its latency is set by the seven pairs of restoring dividers, each pair
// 126 stages deep with one quotient bit per stage, followed by ten Horner
// stages, two stages that scale by 1/y and add 1/(2y^2), a three-stage adder
// tree and the output register. A stall at the output freezes the whole
// pipeline, so s_axis_tready follows m_axis_tready whenever a result is
// waiting. A zero argument returns zero with the invalid flag set; a value
// beyond the Q24.24 range returns all ones with saturated.
// ---------------------------------------------------------------------------
module trigamma_function_unit_core
    import tfu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [X_W-1:0]    s_axis_tdata,   // [31:0] x_value
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [RES_W-1:0]  m_axis_tdata,   // [47:0] result
    output logic [1:0]        m_axis_tuser    // [0] saturated, [1] invalid
);

    localparam logic [Q_W-1:0] DIVIDEND = {1'b1, {(Q_W-1){1'b0}}};

    // The whole pipeline moves together whenever the output slot is free.
    logic adv;
    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    logic [TOTAL_LAT-1:0] vld_reg;
    logic [TOTAL_LAT-2:0] zf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[TOTAL_LAT-2:0], s_axis_tvalid};
        end
    end

    // The zero flag rides along with the data; it is payload and needs no reset.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            zf_reg <= {zf_reg[TOTAL_LAT-3:0], (s_axis_tdata == '0)};
        end
    end

    // Each divider pair forms floor(floor(2^62/d)/d) for d = x + k*2^16.
    // The last pair uses d = y, which gives 1/y^2, and its first quotient
    // shifted down by 16 bits gives 1/y.
    logic [Q_W-1:0] q1_w  [NUM_DIV];
    logic [Q_W-1:0] inv_w [NUM_DIV];

    for (genvar k = 0; k < NUM_DIV; k++)
    begin : g_div
        logic [D_W-1:0] d_k;
        logic [D_W-1:0] d_mid;

        assign d_k = {1'b0, s_axis_tdata} + (D_W'(k) << 16);

        tfu_div #(.NW(Q_W), .DW(D_W)) u_div_a (
            .clk         (clk),
            .en          (adv),
            .dividend    (DIVIDEND),
            .divisor     (d_k),
            .quotient    (q1_w[k]),
            .divisor_out (d_mid)
        );

        tfu_div #(.NW(Q_W), .DW(D_W)) u_div_b (
            .clk         (clk),
            .en          (adv),
            .dividend    (q1_w[k]),
            .divisor     (d_mid),
            .quotient    (inv_w[k]),
            .divisor_out ()
        );
    end

    // 1/y leaves the first divider half way down; hold it until 1/y^2 is ready.
    logic [R_W-1:0] r_dly_reg [Q_W];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_dly_reg[0] <= q1_w[NUM_DIV-1][R_W+15:16];
            for (int i = 1; i < Q_W; i++)
            begin
                r_dly_reg[i] <= r_dly_reg[i-1];
            end
        end
    end

    logic [SER_W-1:0] ser;

    tfu_poly u_poly (
        .clk (clk),
        .en  (adv),
        .p   (inv_w[NUM_DIV-1][P_W-1:0]),
        .r   (r_dly_reg[Q_W-1]),
        .ser (ser)
    );

    // Recurrence terms wait out the series evaluation.
    logic [Q_W-1:0] inv_dly_reg [NUM_TERMS][POLY_LAT];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < NUM_TERMS; k++)
            begin
                inv_dly_reg[k][0] <= inv_w[k];
                for (int i = 1; i < POLY_LAT; i++)
                begin
                    inv_dly_reg[k][i] <= inv_dly_reg[k][i-1];
                end
            end
        end
    end

    // Three-level adder tree over the six terms and the series value.
    logic [SUM_W-1:0] s1_reg [4];
    logic [SUM_W-1:0] s2_reg [2];
    logic [SUM_W-1:0] sum_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg[0] <= SUM_W'(inv_dly_reg[0][POLY_LAT-1])
                       + SUM_W'(inv_dly_reg[1][POLY_LAT-1]);
            s1_reg[1] <= SUM_W'(inv_dly_reg[2][POLY_LAT-1])
                       + SUM_W'(inv_dly_reg[3][POLY_LAT-1]);
            s1_reg[2] <= SUM_W'(inv_dly_reg[4][POLY_LAT-1])
                       + SUM_W'(inv_dly_reg[5][POLY_LAT-1]);
            s1_reg[3] <= SUM_W'(ser);
            s2_reg[0] <= s1_reg[0] + s1_reg[1];
            s2_reg[1] <= s1_reg[2] + s1_reg[3];
            sum_reg   <= s2_reg[0] + s2_reg[1];
        end
    end

    // Drop to Q24.24, then clamp anything above the 48-bit range.
    logic [SUM_W-7:0] val;
    logic             ovf;
    logic             zero_arg;
    logic [RES_W-1:0] result_reg;
    logic             sat_reg;
    logic             inv_reg;

    assign val      = sum_reg[SUM_W-1:6];
    assign ovf      = |val[SUM_W-7:RES_W];
    assign zero_arg = zf_reg[TOTAL_LAT-2];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (zero_arg)
            begin
                result_reg <= '0;
                sat_reg    <= 1'b0;
            end
            else if (ovf)
            begin
                result_reg <= '1;
                sat_reg    <= 1'b1;
            end
            else
            begin
                result_reg <= val[RES_W-1:0];
                sat_reg    <= 1'b0;
            end
            inv_reg <= zero_arg;
        end
    end

    assign m_axis_tvalid = vld_reg[TOTAL_LAT-1];
    assign m_axis_tdata  = result_reg;
    assign m_axis_tuser  = {inv_reg, sat_reg};

endmodule

### rtl/tfu_div.sv
// ---------------------------------------------------------------------------
// tfu_div
// Pipelined restoring divider, one quotient bit per register stage.
// ---------------------------------------------------------------------------
module tfu_div #(
    parameter int NW = 63,
    parameter int DW = 33
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic [NW-1:0] quotient,
    output logic [DW-1:0] divisor_out
);

    logic [DW-1:0] rem_reg [NW];
    logic [NW-1:0] quo_reg [NW];
    logic [DW-1:0] den_reg [NW];

    for (genvar i = 0; i < NW; i++)
    begin : g_stage
        logic [DW-1:0] rem_in;
        logic [NW-1:0] quo_in;
        logic [DW-1:0] den_in;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          ge;

        if (i == 0)
        begin : g_first
            assign rem_in = '0;
            assign quo_in = dividend;
            assign den_in = divisor;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[i-1];
            assign quo_in = quo_reg[i-1];
            assign den_in = den_reg[i-1];
        end

        assign trial = {rem_in, quo_in[NW-1]};
        assign ge    = (trial >= {1'b0, den_in});
        assign diff  = trial - {1'b0, den_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= ge ? diff[DW-1:0] : trial[DW-1:0];
                quo_reg[i] <= {quo_in[NW-2:0], ge};
                den_reg[i] <= den_in;
            end
        end
    end

    assign quotient    = quo_reg[NW-1];
    assign divisor_out = den_reg[NW-1];

endmodule

### rtl/tfu_poly.sv
// ---------------------------------------------------------------------------
// tfu_poly
// Pipelined Horner evaluation of the asymptotic series, two stages per step.
// ---------------------------------------------------------------------------
module tfu_poly
    import tfu_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [P_W-1:0]   p,
    input  logic [R_W-1:0]   r,
    output logic [SER_W-1:0] ser
);

    logic [T_W+P_W-1:0] mag_reg [NUM_STEPS];
    logic               neg_reg [NUM_STEPS];
    logic [P_W-1:0]     pa_reg  [NUM_STEPS];
    logic [R_W-1:0]     ra_reg  [NUM_STEPS];
    logic [T_W-1:0]     t_reg   [NUM_STEPS];
    logic [P_W-1:0]     pb_reg  [NUM_STEPS];
    logic [R_W-1:0]     rb_reg  [NUM_STEPS];

    for (genvar j = 0; j < NUM_STEPS; j++)
    begin : g_step
        logic [T_W-1:0] t_in;
        logic [P_W-1:0] p_in;
        logic [R_W-1:0] r_in;
        logic [T_W-1:0] t_abs;
        logic [T_W-1:0] sh;
        logic [T_W-1:0] term;

        if (j == 0)
        begin : g_first
            assign t_in = COEF_C5;
            assign p_in = p;
            assign r_in = r;
        end
        else
        begin : g_rest
            assign t_in = t_reg[j-1];
            assign p_in = pb_reg[j-1];
            assign r_in = rb_reg[j-1];
        end

        assign t_abs = t_in[T_W-1] ? (~t_in + 32'd1) : t_in;
        assign sh    = T_W'(mag_reg[j][T_W+P_W-1:FRAC_BITS]);
        assign term  = neg_reg[j] ? (~sh + 32'd1) : sh;

        // The product magnitude is truncated, then the sign is put back.
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                mag_reg[j] <= t_abs * p_in;
                neg_reg[j] <= t_in[T_W-1];
                pa_reg[j]  <= p_in;
                ra_reg[j]  <= r_in;
                t_reg[j]   <= term + horner_coef(3'(j));
                pb_reg[j]  <= pa_reg[j];
                rb_reg[j]  <= ra_reg[j];
            end
        end
    end

    logic [T_W-2:0]       t_pos;
    logic [T_W+R_W-2:0]   prod_reg;
    logic [P_W-2:0]       half_p_reg;
    logic [SER_W-1:0]     ser_reg;

    assign t_pos = t_reg[NUM_STEPS-1][T_W-1] ? '0 : t_reg[NUM_STEPS-1][T_W-2:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg   <= t_pos * rb_reg[NUM_STEPS-1];
            half_p_reg <= pb_reg[NUM_STEPS-1][P_W-1:1];
            ser_reg    <= SER_W'(prod_reg[T_W+R_W-2:FRAC_BITS]) + SER_W'(half_p_reg);
        end
    end

    assign ser = ser_reg;

endmodule

### rtl/tfu_checker.sv
// ---------------------------------------------------------------------------
// tfu_checker
// Port-level checks on the trigamma unit, attached by bind.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tfu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [31:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // An invalid argument gives zero and is never marked saturated.
    `ASSERT_CLK(a_invalid_zero, (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata == '0 && !m_axis_tuser[0]), "invalid result not zero")

    // A clamped result is the all-ones code.
    `ASSERT_CLK(a_sat_max, (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '1), "saturated result not all ones")

    // With the output slot empty the pipeline must take input.
    `ASSERT_NEVER(a_ready_when_empty, !m_axis_tvalid && !s_axis_tready, "input stalled while output empty")

    // A result waiting on the output holds its value.
    `ASSERT_CLK(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)), "stalled output transaction changed")

endmodule

bind trigamma_function_unit_core tfu_checker u_tfu_checker (.*);
